// ===== rtl/tkss_pkg.sv =====
// shared types and constants for the top-k score selector
package tkss_pkg;

   // fixed field widths
   localparam int SCORE_W    = 32;
   localparam int INDEX_W    = 12;
   localparam int KEEP_W     = 5;
   localparam int RSP_DATA_W = 48;

   // reset value of the keep count register
   localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(5);

   // parameter defaults
   localparam int DEF_MAX_K     = 16;
   localparam int DEF_MAX_ITEMS = 4096;

   // one kept (index, score) pair
   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [INDEX_W-1:0] index;
   } entry_type;

   // control broadcast to every cell of the chain
   typedef struct packed {
      logic insert;   // rank the broadcast entry into the chain
      logic drain;    // move every entry one cell towards the head
   } cell_ctl_type;

   // sequencer states
   typedef enum logic {
      ST_COLLECT,
      ST_REPORT
   } state_type;

endpackage

// ===== rtl/tkss_cell.sv =====
// one cell of the sorted insertion chain
module tkss_cell import tkss_pkg::*; (
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  entry_type    new_entry,   // broadcast entry to rank
   input  logic         occupied,    // cell holds a kept entry
   input  logic         prev_gt,     // neighbour towards the head lost to the new entry
   input  entry_type    prev_entry,  // neighbour towards the head
   input  entry_type    next_entry,  // neighbour towards the tail
   output logic         gt,          // new entry ranks above this cell
   output entry_type    entry
);

   entry_type entry_ff;
   entry_type entry_in;

   // an empty cell always loses; equal scores keep the older entry in front
   assign gt    = !occupied || ($signed(new_entry.score) > $signed(entry_ff.score));
   assign entry = entry_ff;

   // first losing cell takes the new entry, the ones behind it shift down
   always_comb begin
      entry_in = entry_ff;
      if (ctl.drain) begin
         entry_in = next_entry;
      end else if (ctl.insert && gt) begin
         entry_in = prev_gt ? prev_entry : new_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== rtl/top_k_score_select_core.sv =====
// Streaming top-k score selector. Scores enter one per cycle while a set is
// collected; each is ranked in the same cycle by a chain of MAX_K cells that
// keeps the entries sorted, best first (ties stay in arrival order). The
// entry with the lowest rank drops off the tail when the set is full. On the
// score marked last the chain is drained from its head, one result per cycle
// while the result side accepts them, min(kept, k) results in all, and no
// score is taken meanwhile. The last result stays in the output register
// while the next set is already being taken.
module top_k_score_select_core import tkss_pkg::*; #(
   parameter int MAX_K     = DEF_MAX_K,
   parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
   input  logic                  clock,
   input  logic                  reset,
   // score transactions
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [SCORE_W-1:0]    req_tdata,    // [31:0] score
   input  logic                  req_tlast,    // last score of the set
   // result transactions
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,    // [11:0] class_index, [43:12] best_score, zero pad
   output logic                  rsp_tlast,    // final result of the set
   output logic                  rsp_tuser,    // [0] overflowed
   // keep count register
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [KEEP_W-1:0]     csr_data
);

   localparam int CNT_W  = $clog2(MAX_K + 1);
   localparam int ITEM_W = $clog2(MAX_ITEMS + 1);
   localparam int KW     = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;
   localparam int PAD_W  = RSP_DATA_W - SCORE_W - INDEX_W;

   state_type         state_ff, state_in;
   logic [KEEP_W-1:0] keep_count_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [ITEM_W-1:0] item_cnt_ff, item_cnt_in;
   logic              ovf_ff, ovf_in;

   logic [KW-1:0]     keep_wide;
   logic [CNT_W-1:0]  k_eff;
   logic              req_fire;
   logic              load_out;
   cell_ctl_type      ctl;
   entry_type         new_entry;

   entry_type         cell_entry [MAX_K];
   logic [MAX_K-1:0]  gt;
   logic [MAX_K-1:0]  occupied;

   entry_type         out_entry_ff;
   logic              out_valid_ff;
   logic              out_last_ff;
   logic              out_ovf_ff;

   // keep count register, always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_count_ff <= KEEP_RESET;
      end else if (csr_valid && csr_ready) begin
         keep_count_ff <= csr_data;
      end
   end

   // effective k, clamped to 1..MAX_K
   always_comb begin
      keep_wide = KW'(keep_count_ff);
      if (keep_wide == '0) begin
         k_eff = CNT_W'(1);
      end else if (keep_wide > KW'(MAX_K)) begin
         k_eff = CNT_W'(MAX_K);
      end else begin
         k_eff = CNT_W'(keep_wide);
      end
   end

   // broadcast entry: score with its stream position
   assign new_entry = {req_tdata, INDEX_W'(item_cnt_ff)};
   assign req_fire  = req_tvalid && req_tready;

   // sorted chain of cells
   for (genvar gi = 0; gi < MAX_K; gi++) begin : g_cell
      entry_type prev_e;
      entry_type next_e;
      logic      prev_g;

      if (gi == 0) begin : g_head
         assign prev_g = 1'b0;
         assign prev_e = new_entry;
      end else begin : g_body
         assign prev_g = gt[gi-1];
         assign prev_e = cell_entry[gi-1];
      end

      if (gi == MAX_K - 1) begin : g_tail
         assign next_e = cell_entry[gi];
      end else begin : g_inner
         assign next_e = cell_entry[gi+1];
      end

      assign occupied[gi] = (CNT_W'(gi) < count_ff);

      tkss_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .new_entry  (new_entry),
         .occupied   (occupied[gi]),
         .prev_gt    (prev_g),
         .prev_entry (prev_e),
         .next_entry (next_e),
         .gt         (gt[gi]),
         .entry      (cell_entry[gi])
      );
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_COLLECT;
         count_ff    <= '0;
         rem_ff      <= '0;
         item_cnt_ff <= '0;
         ovf_ff      <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         rem_ff      <= rem_in;
         item_cnt_ff <= item_cnt_in;
         ovf_ff      <= ovf_in;
      end
   end

   // next state, chain control and result loading
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      rem_in      = rem_ff;
      item_cnt_in = item_cnt_ff;
      ovf_in      = ovf_ff;
      ctl         = '0;
      load_out    = 1'b0;
      req_tready  = 1'b0;
      case (state_ff)
         ST_COLLECT: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               // past the item limit: ignore the score, keep the counter saturated
               if (item_cnt_ff == ITEM_W'(MAX_ITEMS)) begin
                  ovf_in = 1'b1;
               end else begin
                  ctl.insert  = 1'b1;
                  item_cnt_in = item_cnt_ff + ITEM_W'(1);
                  if (count_ff < k_eff) begin
                     count_in = count_ff + CNT_W'(1);
                  end
               end
               if (req_tlast) begin
                  state_in = ST_REPORT;
                  rem_in   = (count_in < k_eff) ? count_in : k_eff;
               end
            end
         end
         ST_REPORT: begin
            if (!out_valid_ff || rsp_tready) begin
               load_out  = 1'b1;
               ctl.drain = 1'b1;
               rem_in    = rem_ff - CNT_W'(1);
               // final result taken from the chain: clear the set
               if (rem_ff == CNT_W'(1)) begin
                  state_in    = ST_COLLECT;
                  count_in    = '0;
                  item_cnt_in = '0;
                  ovf_in      = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   // result register, loaded from the head of the chain
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_entry_ff <= cell_entry[0];
         out_last_ff  <= (rem_ff == CNT_W'(1));
         out_ovf_ff   <= ovf_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, out_entry_ff.score, out_entry_ff.index};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_ovf_ff;

   // checks on the sequencer

   // kept count stays within the chain
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_K))
      else $error("kept count exceeds the chain length");

   // a report always has results left to send
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPORT) |-> (rem_ff != '0))
      else $error("report state with nothing left to send");

   // a last score stops intake until the report is done
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tlast) |=> !req_tready)
      else $error("score taken right after the last score of a set");

   // overflow is only flagged once the item counter has saturated
   assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (item_cnt_ff == ITEM_W'(MAX_ITEMS)))
      else $error("overflow flagged below the item limit");

endmodule
